@@ rtl/nns_pkg.sv @@
// Shared constants, types and field layout for the nearest-neighbor scaler.
package nns_pkg;

  localparam int MAX_SOURCE_DIM = 256;
  localparam int MAX_TARGET_DIM = 32768;

  localparam int SDW  = $clog2(MAX_SOURCE_DIM) + 1;
  localparam int SQW  = $clog2(MAX_SOURCE_DIM);
  localparam int TDW  = $clog2(MAX_TARGET_DIM) + 1;
  localparam int LCW  = 8;
  localparam int FCW  = 15;
  localparam int PIXW = 32;
  localparam int AW   = $clog2(MAX_SOURCE_DIM * MAX_SOURCE_DIM);
  localparam int DVW  = FCW + SDW;
  localparam int CW   = (DVW > TDW + SQW) ? DVW : TDW + SQW;
  localparam int CFGW = 16;
  localparam int CIW  = 2;

  localparam int S_TDATA_W  = 80;
  localparam int LX_LSB     = 0;
  localparam int LY_LSB     = LX_LSB + LCW;
  localparam int LPIX_LSB   = LY_LSB + LCW;
  localparam int FX_LSB     = LPIX_LSB + PIXW;
  localparam int FY_LSB     = FX_LSB + FCW;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int ODEPTH = 16;
  localparam int OAW    = $clog2(ODEPTH);
  localparam int RW     = $clog2(ODEPTH + 1);

  typedef enum logic [CIW-1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_TGT_W = 2'd2,
    CFG_TGT_H = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_FETCH = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TDW-1:0] dx;
    logic [TDW-1:0] dy;
  } dims_t;

  typedef struct packed {
    kind_t           kind;
    logic [AW-1:0]   addr;
    logic [PIXW-1:0] pix;
    logic [DVW-1:0]  px;
    logic [DVW-1:0]  py;
  } qent_t;

endpackage

@@ rtl/nns_ram.sv @@
// Generic single-port RAM with registered read.
module nns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/nns_fifo.sv @@
// Short queue between the front and back halves.
module nns_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nns_pkg::qent_t din,
  output logic          full,
  input  logic          pop,
  output nns_pkg::qent_t dout,
  output logic          empty
);

  nns_pkg::qent_t mem [nns_pkg::QDEPTH];
  logic [nns_pkg::QAW-1:0] wp;
  logic [nns_pkg::QAW-1:0] rp;
  logic [nns_pkg::QAW:0]   cnt;

  assign full  = cnt == (nns_pkg::QAW+1)'(nns_pkg::QDEPTH);
  assign empty = cnt == '0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == nns_pkg::QAW'(nns_pkg::QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == nns_pkg::QAW'(nns_pkg::QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (nns_pkg::QAW+1)'(push) - (nns_pkg::QAW+1)'(pop);
    end
  end

endmodule

@@ rtl/nns_front.sv @@
// Front half: configuration registers, beat classification and coordinate products.
module nns_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nns_pkg::CIW-1:0]        cfg_index,
  input  logic [nns_pkg::CFGW-1:0]       cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [nns_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output nns_pkg::qent_t                 q_ent,
  output nns_pkg::dims_t                 dims
);

  logic [nns_pkg::SDW-1:0] src_w;
  logic [nns_pkg::SDW-1:0] src_h;
  logic [nns_pkg::TDW-1:0] tgt_w;
  logic [nns_pkg::TDW-1:0] tgt_h;

  logic [nns_pkg::SDW-1:0]  sw;
  logic [nns_pkg::SDW-1:0]  sh;
  logic [nns_pkg::TDW-1:0]  tw;
  logic [nns_pkg::TDW-1:0]  th;
  logic [nns_pkg::LCW-1:0]  lx;
  logic [nns_pkg::LCW-1:0]  ly;
  logic [nns_pkg::PIXW-1:0] lpix;
  logic [nns_pkg::FCW-1:0]  fx;
  logic [nns_pkg::FCW-1:0]  fy;
  logic                     load_bad;
  logic                     fetch_bad;

  function automatic logic [nns_pkg::SDW-1:0] clamp_src(input logic [nns_pkg::SDW-1:0] v);
    logic [nns_pkg::SDW-1:0] r;
    if (v == '0) begin
      r = nns_pkg::SDW'(1);
    end else if (v > nns_pkg::SDW'(nns_pkg::MAX_SOURCE_DIM)) begin
      r = nns_pkg::SDW'(nns_pkg::MAX_SOURCE_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [nns_pkg::TDW-1:0] clamp_tgt(input logic [nns_pkg::TDW-1:0] v);
    return (v > nns_pkg::TDW'(nns_pkg::MAX_TARGET_DIM)) ?
           nns_pkg::TDW'(nns_pkg::MAX_TARGET_DIM) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= nns_pkg::SDW'(nns_pkg::MAX_SOURCE_DIM);
      src_h <= nns_pkg::SDW'(nns_pkg::MAX_SOURCE_DIM);
      tgt_w <= '0;
      tgt_h <= '0;
    end else if (cfg_we) begin
      unique case (nns_pkg::cfg_idx_t'(cfg_index))
        nns_pkg::CFG_SRC_W: src_w <= cfg_data[nns_pkg::SDW-1:0];
        nns_pkg::CFG_SRC_H: src_h <= cfg_data[nns_pkg::SDW-1:0];
        nns_pkg::CFG_TGT_W: tgt_w <= cfg_data[nns_pkg::TDW-1:0];
        nns_pkg::CFG_TGT_H: tgt_h <= cfg_data[nns_pkg::TDW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sw = clamp_src(src_w);
    sh = clamp_src(src_h);
    tw = clamp_tgt(tgt_w);
    th = clamp_tgt(tgt_h);
    if (tw == '0 || th == '0) begin
      dims.dx = nns_pkg::TDW'(sw);
      dims.dy = nns_pkg::TDW'(sh);
    end else begin
      dims.dx = tw;
      dims.dy = th;
    end
  end

  assign lx   = s_tdata[nns_pkg::LX_LSB +: nns_pkg::LCW];
  assign ly   = s_tdata[nns_pkg::LY_LSB +: nns_pkg::LCW];
  assign lpix = s_tdata[nns_pkg::LPIX_LSB +: nns_pkg::PIXW];
  assign fx   = s_tdata[nns_pkg::FX_LSB +: nns_pkg::FCW];
  assign fy   = s_tdata[nns_pkg::FY_LSB +: nns_pkg::FCW];

  assign load_bad  = (nns_pkg::SDW'(lx) >= sw) || (nns_pkg::SDW'(ly) >= sh);
  assign fetch_bad = (nns_pkg::TDW'(fx) >= dims.dx) || (nns_pkg::TDW'(fy) >= dims.dy);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    if (nns_pkg::op_t'(s_tuser) == nns_pkg::OP_LOAD) begin
      q_ent.kind = load_bad ? nns_pkg::KIND_ERROR : nns_pkg::KIND_LOAD;
    end else begin
      q_ent.kind = fetch_bad ? nns_pkg::KIND_ERROR : nns_pkg::KIND_FETCH;
    end
    q_ent.addr = nns_pkg::AW'(nns_pkg::AW'(ly) * nns_pkg::AW'(nns_pkg::MAX_SOURCE_DIM))
                 + nns_pkg::AW'(lx);
    q_ent.pix  = lpix;
    q_ent.px   = nns_pkg::DVW'(fx) * nns_pkg::DVW'(sw);
    q_ent.py   = nns_pkg::DVW'(fy) * nns_pkg::DVW'(sh);
  end

endmodule

@@ rtl/nns_back.sv @@
// Back half: pipelined coordinate divider, pixel store access and output buffer.
module nns_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  nns_pkg::qent_t             q_head,
  output logic                       q_pop,
  input  nns_pkg::dims_t             dims,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [nns_pkg::PIXW-1:0]   m_tdata,
  output logic                       m_tuser
);

  typedef struct packed {
    nns_pkg::kind_t           kind;
    logic [nns_pkg::AW-1:0]   addr;
    logic [nns_pkg::PIXW-1:0] pix;
    logic [nns_pkg::DVW-1:0]  rx;
    logic [nns_pkg::DVW-1:0]  ry;
    logic [nns_pkg::SQW-1:0]  qx;
    logic [nns_pkg::SQW-1:0]  qy;
  } stage_t;

  typedef struct packed {
    logic [nns_pkg::PIXW-1:0] pixel;
    logic                     status;
  } obeat_t;

  stage_t st  [nns_pkg::SQW+1];
  logic   vld [nns_pkg::SQW+1];

  logic [nns_pkg::RW-1:0] resv;
  logic                   fin_vld;
  nns_pkg::kind_t         fin_kind;
  logic                   ram_we;
  logic [nns_pkg::AW-1:0] ram_addr;
  logic [nns_pkg::AW-1:0] fetch_addr;
  logic [nns_pkg::PIXW-1:0] ram_rdata;
  logic                   opush;
  logic                   obeat;
  logic                   load_done;
  obeat_t                 ofifo [nns_pkg::ODEPTH];
  logic [nns_pkg::OAW-1:0] ohead;
  logic [nns_pkg::OAW-1:0] otail;
  logic [nns_pkg::OAW:0]   ocnt;

  assign q_pop = !q_empty && (resv < nns_pkg::RW'(nns_pkg::ODEPTH));

  always_ff @(posedge clk) begin
    st[0].kind <= q_head.kind;
    st[0].addr <= q_head.addr;
    st[0].pix  <= q_head.pix;
    st[0].rx   <= q_head.px;
    st[0].ry   <= q_head.py;
    st[0].qx   <= '0;
    st[0].qy   <= '0;
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= q_pop;
    end
  end

  // restoring division, one quotient bit per stage, quotient known below 2^SQW
  for (genvar i = 0; i < nns_pkg::SQW; i++) begin : g_div
    localparam int B = nns_pkg::SQW - 1 - i;
    logic [nns_pkg::CW-1:0] dxs;
    logic [nns_pkg::CW-1:0] dys;
    stage_t                 nxt;

    assign dxs = nns_pkg::CW'(dims.dx) << B;
    assign dys = nns_pkg::CW'(dims.dy) << B;

    always_comb begin
      nxt = st[i];
      if (nns_pkg::CW'(st[i].rx) >= dxs) begin
        nxt.rx    = st[i].rx - nns_pkg::DVW'(dxs);
        nxt.qx[B] = 1'b1;
      end
      if (nns_pkg::CW'(st[i].ry) >= dys) begin
        nxt.ry    = st[i].ry - nns_pkg::DVW'(dys);
        nxt.qy[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      st[i+1] <= nxt;
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign fetch_addr = nns_pkg::AW'(nns_pkg::AW'(st[nns_pkg::SQW].qy)
                      * nns_pkg::AW'(nns_pkg::MAX_SOURCE_DIM))
                      + nns_pkg::AW'(st[nns_pkg::SQW].qx);
  assign ram_we   = vld[nns_pkg::SQW] && st[nns_pkg::SQW].kind == nns_pkg::KIND_LOAD;
  assign ram_addr = (st[nns_pkg::SQW].kind == nns_pkg::KIND_LOAD) ?
                    st[nns_pkg::SQW].addr : fetch_addr;

  nns_ram #(
    .WIDTH(nns_pkg::PIXW),
    .DEPTH(nns_pkg::MAX_SOURCE_DIM * nns_pkg::MAX_SOURCE_DIM)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(st[nns_pkg::SQW].pix),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    fin_kind <= st[nns_pkg::SQW].kind;
    if (rst) begin
      fin_vld <= 1'b0;
    end else begin
      fin_vld <= vld[nns_pkg::SQW];
    end
  end

  assign opush     = fin_vld && fin_kind != nns_pkg::KIND_LOAD;
  assign load_done = fin_vld && fin_kind == nns_pkg::KIND_LOAD;
  assign obeat     = m_tvalid && m_tready;

  assign m_tvalid = ocnt != '0;
  assign m_tdata  = ofifo[ohead].pixel;
  assign m_tuser  = ofifo[ohead].status;

  always_ff @(posedge clk) begin
    if (opush) begin
      ofifo[otail].pixel  <= (fin_kind == nns_pkg::KIND_ERROR) ? '0 : ram_rdata;
      ofifo[otail].status <= fin_kind == nns_pkg::KIND_ERROR;
    end
    if (rst) begin
      ohead <= '0;
      otail <= '0;
      ocnt  <= '0;
      resv  <= '0;
    end else begin
      if (opush) begin
        otail <= (otail == nns_pkg::OAW'(nns_pkg::ODEPTH - 1)) ? '0 : otail + 1'b1;
      end
      if (obeat) begin
        ohead <= (ohead == nns_pkg::OAW'(nns_pkg::ODEPTH - 1)) ? '0 : ohead + 1'b1;
      end
      ocnt <= ocnt + (nns_pkg::OAW+1)'(opush) - (nns_pkg::OAW+1)'(obeat);
      resv <= resv + nns_pkg::RW'(q_pop) - nns_pkg::RW'(obeat) - nns_pkg::RW'(load_done);
    end
  end

endmodule

@@ rtl/nearest_neighbor_scaler_top.sv @@
// Top level of the nearest-neighbor scaler.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: load_x, load_y, load_pixel, fetch_x, fetch_y
//                                    tuser: operation
//   m_*      out  m_tvalid/m_tready  tdata: pixel; tuser: status
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One beat per cycle in both directions when neither side stalls.
// The path from input to output beat runs through the queue, the divider pipeline (one stage
// per source coordinate bit), the pixel store read and the output buffer.
// Reset clears control only; the pixel store holds garbage until loaded.
// Output stalls back up through a 16-entry buffer and a 4-entry queue to s_tready.
module nearest_neighbor_scaler_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nns_pkg::CIW-1:0]        cfg_index,
  input  logic [nns_pkg::CFGW-1:0]       cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // load_x[7:0], load_y[15:8], load_pixel[47:16], fetch_x[62:48], fetch_y[77:63]
  input  logic [nns_pkg::S_TDATA_W-1:0]  s_tdata,
  // operation
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel
  output logic [nns_pkg::PIXW-1:0]       m_tdata,
  // status
  output logic                           m_tuser
);

  nns_pkg::qent_t q_in;
  nns_pkg::qent_t q_head;
  nns_pkg::dims_t dims;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  nns_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ent    (q_in),
    .dims     (dims)
  );

  nns_fifo u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_head),
    .empty(q_empty)
  );

  nns_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .dims    (dims),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst) !s_tready |-> q_full)
    else $error("input stalled with room in queue");

  a_err_pixel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("error beat carries nonzero pixel");

endmodule

@@ verif/tb_nearest_neighbor_scaler_top.sv @@
// Testbench for the nearest-neighbor scaler: directed and random stream traffic checked against a predictor.
`timescale 1ns / 1ps

class nns_scoreboard;
  bit [31:0] frame [int];
  int unsigned src_w, src_h, tgt_w, tgt_h;
  bit [32:0] pending [$];
  int errors;

  function new();
    src_w = 256; src_h = 256; tgt_w = 0; tgt_h = 0; errors = 0;
  endfunction

  function void set_reg(nns_pkg::cfg_idx_t idx, bit [15:0] v);
    case (idx)
      nns_pkg::CFG_SRC_W: src_w = v[8:0];
      nns_pkg::CFG_SRC_H: src_h = v[8:0];
      nns_pkg::CFG_TGT_W: tgt_w = v;
      nns_pkg::CFG_TGT_H: tgt_h = v;
      default: ;
    endcase
  endfunction

  function int unsigned eff_src(int unsigned v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function int unsigned scale_coord(int unsigned t, int unsigned s, int unsigned g);
    longint unsigned r;
    r = (longint'(t) * s) / g;
    if (r > s - 1) r = s - 1;
    return r;
  endfunction

  function void note_beat(bit op, bit [79:0] d);
    int unsigned sw, sh, tw, th, fx, fy, sx, sy;
    sw = eff_src(src_w); sh = eff_src(src_h);
    tw = (tgt_w > 32768) ? 32768 : tgt_w;
    th = (tgt_h > 32768) ? 32768 : tgt_h;
    if (op == nns_pkg::OP_LOAD) begin
      if (d[7:0] >= sw || d[15:8] >= sh) pending.push_back({1'b1, 32'd0});
      else frame[d[15:8] * 256 + d[7:0]] = d[47:16];
      return;
    end
    if (tw == 0 || th == 0) begin
      tw = sw; th = sh;
    end
    fx = d[62:48]; fy = d[77:63];
    if (fx >= tw || fy >= th) begin
      pending.push_back({1'b1, 32'd0});
      return;
    end
    sx = scale_coord(fx, sw, tw);
    sy = scale_coord(fy, sh, th);
    pending.push_back({1'b0, frame.exists(sy * 256 + sx) ? frame[sy * 256 + sx] : 32'd0});
  endfunction

  function bit written(int unsigned fx, int unsigned fy);
    int unsigned sw, sh, tw, th;
    sw = eff_src(src_w); sh = eff_src(src_h);
    tw = (tgt_w > 32768) ? 32768 : tgt_w;
    th = (tgt_h > 32768) ? 32768 : tgt_h;
    if (tw == 0 || th == 0) begin
      tw = sw; th = sh;
    end
    if (fx >= tw || fy >= th) return 1;
    return frame.exists(scale_coord(fy, sh, th) * 256 + scale_coord(fx, sw, tw));
  endfunction

  function void check_beat(bit [31:0] pix, bit st);
    bit [32:0] e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat pixel=%h status=%b", $time, pix, st);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[31:0] !== pix) begin
      $display("%0t: pixel expected %h actual %h", $time, e[31:0], pix);
      errors++;
    end
    if (e[32] !== st) begin
      $display("%0t: status expected %b actual %b", $time, e[32], st);
      errors++;
    end
  endfunction
endclass

module tb_nearest_neighbor_scaler_top;

  logic clk, rst;
  logic cfg_we;
  logic [nns_pkg::CIW-1:0] cfg_index;
  logic [nns_pkg::CFGW-1:0] cfg_data;
  logic s_tvalid, s_tready, s_tuser;
  logic [nns_pkg::S_TDATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready, m_tuser;
  logic [nns_pkg::PIXW-1:0] m_tdata;

  nns_scoreboard sb;
  int hold_off;
  bit rx_random;

  nearest_neighbor_scaler_top i_dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_nearest_neighbor_scaler_top NOT OK");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else if (rx_random) m_tready <= ($urandom_range(0, 3) != 0);
    else m_tready <= 1'b1;
  end

  task automatic send_beat(bit op, bit [79:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(op, d);
  endtask

  task automatic load_px(int x, int y, bit [31:0] p);
    send_beat(nns_pkg::OP_LOAD, {2'b0, 15'd0, 15'd0, p, y[7:0], x[7:0]});
  endtask

  task automatic fetch_px(int x, int y);
    send_beat(nns_pkg::OP_FETCH, {2'b0, y[14:0], x[14:0], 32'd0, 16'd0});
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_cfg(nns_pkg::cfg_idx_t idx, int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v[15:0]);
  endtask

  task automatic setup(int sw, int sh, int tw, int th);
    drain();
    set_cfg(nns_pkg::CFG_SRC_W, sw);
    set_cfg(nns_pkg::CFG_SRC_H, sh);
    set_cfg(nns_pkg::CFG_TGT_W, tw);
    set_cfg(nns_pkg::CFG_TGT_H, th);
  endtask

  // random fetch limited to out-of-range coordinates or mapped entries already written
  task automatic rand_fetch(int tw, int th);
    int x, y, tries;
    tries = 0;
    do begin
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom_range(0, 32767); y = $urandom_range(0, 32767);
      end else begin
        x = $urandom_range(0, tw); y = $urandom_range(0, th);
      end
      tries++;
    end while (!sb.written(x, y) && tries < 50);
    if (sb.written(x, y)) fetch_px(x, y);
  endtask

  task automatic load_frame(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) load_px(x, y, $urandom());
  endtask

  task automatic random_phase(int sw, int sh, int tw, int th, int n);
    int ew, eh;
    setup(sw, sh, tw, th);
    ew = (tw == 0 || th == 0) ? sw : tw;
    eh = (tw == 0 || th == 0) ? sh : th;
    load_frame(sw, sh);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0)
        load_px($urandom_range(0, 255), $urandom_range(0, 255), $urandom());
      else rand_fetch(ew, eh);
    end
  endtask

  initial begin
    sb = new();
    rst = 1; cfg_we = 0; cfg_index = nns_pkg::CFG_SRC_W; cfg_data = 0;
    s_tvalid = 0; s_tuser = 0; s_tdata = 0; m_tready = 0;
    hold_off = 0; rx_random = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    // directed: tiny frame, extremes, bad coordinates
    setup(2, 2, 0, 0);
    load_px(0, 0, 32'h0000_0000);
    load_px(1, 0, 32'hFFFF_FFFF);
    load_px(0, 1, 32'hA5A5_5A5A);
    load_px(1, 1, 32'h5A5A_A5A5);
    load_px(255, 255, 32'h1234_5678);
    load_px(2, 0, 32'h1);
    fetch_px(0, 0); fetch_px(1, 1); fetch_px(1, 0);
    fetch_px(2, 0); fetch_px(32767, 32767);
    setup(2, 2, 32768, 32768);
    fetch_px(0, 0); fetch_px(32767, 32767); fetch_px(16384, 0);
    setup(2, 2, 5, 0);
    fetch_px(1, 1);
    setup(0, 0, 1, 1);
    load_px(0, 0, 32'hDEAD_BEEF);
    fetch_px(0, 0); fetch_px(1, 0);
    setup(511, 300, 65535, 3);
    load_px(255, 170, 32'hCAFE_F00D);
    fetch_px(32767, 2); fetch_px(0, 3);
    rx_random = 1;
    random_phase(3, 5, 7, 2, 45);
    random_phase(8, 4, 3, 11, 45);
    random_phase(1, 6, 0, 9, 40);
    random_phase(5, 5, 32768, 1, 45);
    // back pressure: stall receiver while sender keeps going
    drain();
    hold_off = 300;
    random_phase(6, 3, 13, 13, 80);
    random_phase(4, 7, 40, 2, 45);
    random_phase(9, 9, 0, 0, 45);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_nearest_neighbor_scaler_top OK");
    else
      $display("tb_nearest_neighbor_scaler_top NOT OK");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/nns_pkg.sv
rtl/nns_ram.sv
rtl/nns_fifo.sv
rtl/nns_front.sv
rtl/nns_back.sv
rtl/nearest_neighbor_scaler_top.sv
verif/tb_nearest_neighbor_scaler_top.sv
